// ----- sv/xyz_pkg.sv -----
// Shared types and fixed constants of the XYZ to sRGB converter.
`timescale 1ns / 1ps

package xyz_pkg;

  localparam int MAT_STAGES = 2;
  localparam int GAM_STAGES = 4;
  localparam int PIPE_DEPTH = MAT_STAGES + GAM_STAGES;
  localparam int S_W = 34;
  localparam int FRAC_W = 27;
  localparam int PROD_W = 32;

  typedef struct packed {
    logic [15:0] x_in;
    logic [15:0] y_in;
    logic [15:0] z_in;
  } xyz_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } rgb_t;

  typedef logic signed [15:0] coef_t;
  typedef logic signed [S_W-1:0] lin_t;
  typedef logic [MAT_STAGES-1:0] mat_en_t;
  typedef logic [GAM_STAGES-1:0] gam_en_t;

  localparam coef_t COEF [3][3] = '{
    '{ 16'sd26547, -16'sd12593, -16'sd4085 },
    '{ -16'sd7937,  16'sd15367,  16'sd340  },
    '{ 16'sd456,   -16'sd1671,   16'sd8659 }
  };

  typedef enum logic [1:0] {
    ENC_ZERO,
    ENC_FULL,
    ENC_LIN,
    ENC_POW
  } enc_class_t;

endpackage

// ----- sv/xyz_to_srgb_converter.sv -----
// Top level of the XYZ to sRGB converter: stage control and channel encoders.
`timescale 1ns / 1ps

// Converts one CIE XYZ pixel (unsigned Q2.14) to one gamma-encoded sRGB pixel
// (16-bit fractions) per clock, unless out_ready stalls the output. A pixel
// passes six register stages, two for the matrix product and four for the
// gamma encoder, and its result is offered from the last of them.
// Every stage stalls on its own, so bubbles are squeezed out and new pixels
// are taken while a result waits. The gamma table of GAMMA_TABLE_SEGMENTS + 1
// entries is constant logic computed at elaboration, one copy per channel.
module xyz_to_srgb_converter
  import xyz_pkg::*;
#(
  parameter int GAMMA_TABLE_SEGMENTS = 64
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  xyz_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rgb_t out_data
);

  logic [PIPE_DEPTH-1:0] v_r;
  logic [PIPE_DEPTH-1:0] v_nxt;
  logic [PIPE_DEPTH-1:0] en;
  lin_t                  lin [3];
  logic [15:0]           val [3];

  always_comb begin
    en[PIPE_DEPTH-1] = !v_r[PIPE_DEPTH-1] || out_ready;
    for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int i = 1; i < PIPE_DEPTH; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  xyz_matrix u_matrix (
    .clk     (clk),
    .en      (en[MAT_STAGES-1:0]),
    .in_data (in_data),
    .lin_o   (lin)
  );

  for (genvar c = 0; c < 3; c++) begin : g_ch
    xyz_gamma #(
      .SEG (GAMMA_TABLE_SEGMENTS)
    ) u_gamma (
      .clk   (clk),
      .en    (en[PIPE_DEPTH-1:MAT_STAGES]),
      .s_i   (lin[c]),
      .val_o (val[c])
    );
  end

  assign in_ready = en[0];
  assign out_valid = v_r[PIPE_DEPTH-1];
  assign out_data.red = val[0];
  assign out_data.green = val[1];
  assign out_data.blue = val[2];

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted transfer did not enter the first stage");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r) && !out_ready |-> !in_ready)
    else $error("full stalled pipeline still takes input");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones(v_r) <= $past($countones(v_r)) + 1) &&
             ($countones(v_r) + 1 >= $past($countones(v_r))))
    else $error("pipeline occupancy changed by more than one");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && (v_r[PIPE_DEPTH-2] || !$past(v_r[PIPE_DEPTH-2]) ||
                                             !$past(en[PIPE_DEPTH-2])))
    else $error("stalled stage lost its item");
`endif

endmodule

// ----- sv/xyz_matrix.sv -----
// Two-stage 3x3 matrix product from XYZ to signed linear RGB.
`timescale 1ns / 1ps

module xyz_matrix
  import xyz_pkg::*;
(
  input  logic    clk,
  input  mat_en_t en,
  input  xyz_t    in_data,
  output lin_t    lin_o [3]
);

  logic [15:0]              comp      [3];
  logic signed [PROD_W:0]   prod_full [3][3];
  logic signed [PROD_W-1:0] prod_nxt  [3][3];
  logic signed [PROD_W-1:0] prod_r    [3][3];
  lin_t                     sum_nxt   [3];
  lin_t                     sum_r     [3];

  assign comp[0] = in_data.x_in;
  assign comp[1] = in_data.y_in;
  assign comp[2] = in_data.z_in;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int j = 0; j < 3; j++) begin
        prod_full[c][j] = COEF[c][j] * $signed({1'b0, comp[j]});
        prod_nxt[c][j]  = prod_full[c][j][PROD_W-1:0];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_nxt[c] = prod_r[c][0] + prod_r[c][1] + prod_r[c][2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r <= prod_nxt;
    end
    if (en[1]) begin
      sum_r <= sum_nxt;
    end
  end

  assign lin_o = sum_r;

endmodule

// ----- sv/xyz_gamma.sv -----
// Four-stage sRGB gamma encoder for one channel with a piecewise-linear power table.
`timescale 1ns / 1ps

module xyz_gamma
  import xyz_pkg::*;
#(
  parameter int SEG = 64
)
(
  input  logic        clk,
  input  gam_en_t     en,
  input  lin_t        s_i,
  output logic [15:0] val_o
);

  localparam int IDX_W = $clog2(SEG + 1);
  localparam int P_W = FRAC_W + IDX_W;
  localparam logic [P_W-1:0] SEG_U = P_W'(SEG);
  localparam logic [FRAC_W-1:0] LIN_LIMIT = 27'd420208;
  localparam longint unsigned LIN_LIMIT_U = 420208;
  localparam logic [45:0] LIN_MUL = 46'd84671220;
  localparam logic [45:0] LIN_BIAS = 46'd50 << FRAC_W;
  localparam logic [34:0] LIN_RECIP = 35'd167773;
  localparam logic [43:0] RND = 44'd1 << (FRAC_W - 1);
  localparam logic [63:0] LIN_MUL64 = 64'd84671220;
  localparam logic [63:0] LIN_BIAS64 = 64'd50 << FRAC_W;
  localparam logic [63:0] LIN_DIV = 64'd100 << FRAC_W;
  localparam logic [63:0] PE_MUL = 64'd69139425;
  localparam logic [63:0] PE_BIAS = 64'd500 << 32;
  localparam logic [63:0] PE_OFF = 64'd3604425 << 32;
  localparam logic [63:0] PE_DIV = 64'd1000 << 32;

  function automatic logic [63:0] mul_hi(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return p[127:64];
  endfunction

  function automatic logic [15:0] lin_entry(input logic [63:0] v);
    logic [63:0] o;
    o = (v * LIN_MUL64 + LIN_BIAS64) / LIN_DIV;
    return (o > 64'd65535) ? 16'hFFFF : o[15:0];
  endfunction

  function automatic logic [15:0] pow_entry(input logic [63:0] d);
    logic [63:0] d2, d4, d5, r, c, c64, c2, c4, c8, c12, num, o;
    d2 = mul_hi(d, d);
    d4 = mul_hi(d2, d2);
    d5 = mul_hi(d4, d);
    r = 64'd0;
    for (int b = 31; b >= 0; b--) begin
      c   = r | (64'd1 << b);
      c64 = c << 32;
      c2  = mul_hi(c64, c64);
      c4  = mul_hi(c2, c2);
      c8  = mul_hi(c4, c4);
      c12 = mul_hi(c8, c4);
      if (c12 <= d5) begin
        r = c;
      end
    end
    num = r * PE_MUL + PE_BIAS;
    if (num < PE_OFF) begin
      return 16'd0;
    end
    o = (num - PE_OFF) / PE_DIV;
    return (o > 64'd65535) ? 16'hFFFF : o[15:0];
  endfunction

  logic [15:0] gtab [0:SEG];

  for (genvar k = 0; k <= SEG; k++) begin : g_tab
    localparam longint unsigned KU = k;
    localparam longint unsigned SEGL = SEG;
    localparam longint unsigned VK = (KU << FRAC_W) / SEGL;
    localparam longint unsigned DK = ((KU << 53) / SEGL) << 11;
    if (k == SEG) begin : g_top
      assign gtab[k] = 16'hFFFF;
    end else if (VK <= LIN_LIMIT_U) begin : g_lin
      assign gtab[k] = lin_entry(64'(VK));
    end else begin : g_pow
      assign gtab[k] = pow_entry(64'(DK));
    end
  end

  enc_class_t        cls_nxt;
  logic [FRAC_W-1:0] v;
  logic [45:0]       lin_a_nxt;
  logic [P_W-1:0]    p_nxt;

  enc_class_t        cls_a_r;
  logic [45:0]       lin_a_r;
  logic [P_W-1:0]    p_a_r;

  always_comb begin
    v = s_i[FRAC_W-1:0];
    if (s_i[S_W-1] || (s_i == '0)) begin
      cls_nxt = ENC_ZERO;
    end else if (|s_i[S_W-2:FRAC_W]) begin
      cls_nxt = ENC_FULL;
    end else if (v <= LIN_LIMIT) begin
      cls_nxt = ENC_LIN;
    end else begin
      cls_nxt = ENC_POW;
    end
    lin_a_nxt = {27'b0, v[18:0]} * LIN_MUL + LIN_BIAS;
    p_nxt = {{(P_W - FRAC_W){1'b0}}, v} * SEG_U;
  end

  logic [16:0]       q;
  logic [34:0]       lin_b_nxt;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  idx1;

  enc_class_t        cls_b_r;
  logic [34:0]       lin_b_r;
  logic [15:0]       t0_b_r;
  logic [15:0]       t1_b_r;
  logic [FRAC_W-1:0] f_b_r;

  always_comb begin
    q = lin_a_r[45:29];
    lin_b_nxt = {18'b0, q} * LIN_RECIP;
    idx = p_a_r[P_W-1:FRAC_W];
    idx1 = idx + 1'b1;
  end

  logic              up;
  logic [15:0]       diff;
  logic [43:0]       rnd_nxt;

  enc_class_t        cls_c_r;
  logic [15:0]       lin_c_r;
  logic [15:0]       t0_c_r;
  logic              up_c_r;
  logic [43:0]       rnd_c_r;

  always_comb begin
    up = (t1_b_r >= t0_b_r);
    diff = up ? (t1_b_r - t0_b_r) : (t0_b_r - t1_b_r);
    rnd_nxt = {28'b0, diff} * {17'b0, f_b_r} + RND;
  end

  logic [16:0] delta;
  logic [16:0] up_sum;
  logic [15:0] pow_val;
  logic [15:0] val_nxt;
  logic [15:0] val_r;

  always_comb begin
    delta = rnd_c_r[43:FRAC_W];
    up_sum = {1'b0, t0_c_r} + delta;
    if (up_c_r) begin
      pow_val = up_sum[16] ? 16'hFFFF : up_sum[15:0];
    end else if (delta > {1'b0, t0_c_r}) begin
      pow_val = 16'd0;
    end else begin
      pow_val = t0_c_r - delta[15:0];
    end
    case (cls_c_r)
      ENC_ZERO: val_nxt = 16'd0;
      ENC_FULL: val_nxt = 16'hFFFF;
      ENC_LIN:  val_nxt = lin_c_r;
      ENC_POW:  val_nxt = pow_val;
      default:  val_nxt = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cls_a_r <= cls_nxt;
      lin_a_r <= lin_a_nxt;
      p_a_r   <= p_nxt;
    end
    if (en[1]) begin
      cls_b_r <= cls_a_r;
      lin_b_r <= lin_b_nxt;
      t0_b_r  <= gtab[idx];
      t1_b_r  <= gtab[idx1];
      f_b_r   <= p_a_r[FRAC_W-1:0];
    end
    if (en[2]) begin
      cls_c_r <= cls_b_r;
      lin_c_r <= {3'b0, lin_b_r[34:22]};
      t0_c_r  <= t0_b_r;
      up_c_r  <= up;
      rnd_c_r <= rnd_nxt;
    end
    if (en[3]) begin
      val_r <= val_nxt;
    end
  end

  assign val_o = val_r;

endmodule
